// ===== design/hts_pkg.sv =====
package hts_pkg;

    typedef struct packed {
        logic [7:0] char_code;
        logic       start_scan;
        logic       close_mode;
        logic       line_end;
    } item_t;

    typedef struct packed {
        logic [1:0] scan_status;
        logic [7:0] name_char;
        logic       name_valid;
        logic       name_last;
    } result_t;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_LT      = 4'd1,
        PH_TAG     = 4'd2,
        PH_SPACE   = 4'd3,
        PH_ATTR    = 4'd4,
        PH_STR     = 4'd5,
        PH_ESC     = 4'd6,
        PH_C_LT    = 4'd7,
        PH_C_SLASH = 4'd8,
        PH_C_NAME  = 4'd9,
        PH_BEGIN   = 4'd10
    } phase_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_BUSY = 2'd1,
        ST_DONE = 2'd2,
        ST_FAIL = 2'd3
    } status_t;

    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_Z   = 8'h5A;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_Z   = 8'h7A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CASE_GAP  = CH_LO_A - CH_UP_A;

    function automatic logic is_space(input logic [7:0] c);
        is_space = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic is_upper(input logic [7:0] c);
        is_upper = (c >= CH_UP_A && c <= CH_UP_Z);
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        is_letter = is_upper(c) || (c >= CH_LO_A && c <= CH_LO_Z);
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        to_lower = is_upper(c) ? c + CASE_GAP : c;
    endfunction

endpackage

// ===== design/hts_step.sv =====
module hts_step (
    input  hts_pkg::item_t   item,
    input  hts_pkg::phase_t  phase,
    input  logic             is_close,
    output hts_pkg::phase_t  phase_next,
    output logic             is_close_next,
    output hts_pkg::result_t result
);

    hts_pkg::phase_t  ph;
    hts_pkg::phase_t  nxt;
    hts_pkg::status_t st;
    logic [7:0]       c;
    logic [7:0]       nch;
    logic             nvalid;
    logic             nlast;
    logic             cls;

    always_comb begin
        c      = item.char_code;
        ph     = item.start_scan ? hts_pkg::PH_BEGIN : phase;
        cls    = item.start_scan ? item.close_mode : is_close;
        nxt    = ph;
        st     = hts_pkg::ST_BUSY;
        nch    = '0;
        nvalid = 1'b0;
        nlast  = 1'b0;

        unique case (ph)
            hts_pkg::PH_BEGIN: begin
                if (c == hts_pkg::CH_LT) begin
                    nxt = cls ? hts_pkg::PH_C_LT : hts_pkg::PH_LT;
                end
                else begin
                    st = hts_pkg::ST_FAIL;
                end
            end
            hts_pkg::PH_LT: begin
                priority if (hts_pkg::is_space(c)) begin
                    nxt = ph;
                end
                else if (hts_pkg::is_letter(c)) begin
                    nxt    = hts_pkg::PH_TAG;
                    nch    = hts_pkg::to_lower(c);
                    nvalid = 1'b1;
                end
                else begin
                    st = hts_pkg::ST_FAIL;
                end
            end
            hts_pkg::PH_TAG: begin
                priority if (hts_pkg::is_space(c)) begin
                    nxt   = hts_pkg::PH_SPACE;
                    nlast = 1'b1;
                end
                else if (c == hts_pkg::CH_GT) begin
                    st    = hts_pkg::ST_DONE;
                    nlast = 1'b1;
                end
                else begin
                    nch    = hts_pkg::to_lower(c);
                    nvalid = 1'b1;
                end
            end
            hts_pkg::PH_SPACE: begin
                priority if (hts_pkg::is_space(c)) begin
                    nxt = ph;
                end
                else if (c == hts_pkg::CH_GT) begin
                    st = hts_pkg::ST_DONE;
                end
                else if (c == hts_pkg::CH_QUOTE) begin
                    nxt = hts_pkg::PH_STR;
                end
                else begin
                    nxt = hts_pkg::PH_ATTR;
                end
            end
            hts_pkg::PH_ATTR: begin
                if (c == hts_pkg::CH_QUOTE) begin
                    nxt = hts_pkg::PH_STR;
                end
                else if (c == hts_pkg::CH_GT) begin
                    st = hts_pkg::ST_DONE;
                end
            end
            hts_pkg::PH_STR: begin
                if (c == hts_pkg::CH_QUOTE) begin
                    nxt = hts_pkg::PH_ATTR;
                end
                else if (c == hts_pkg::CH_BSLASH) begin
                    nxt = hts_pkg::PH_ESC;
                end
            end
            hts_pkg::PH_ESC: begin
                nxt = hts_pkg::PH_STR;
            end
            hts_pkg::PH_C_LT: begin
                priority if (hts_pkg::is_space(c)) begin
                    nxt = ph;
                end
                else if (c == hts_pkg::CH_SLASH) begin
                    nxt = hts_pkg::PH_C_SLASH;
                end
                else begin
                    st = hts_pkg::ST_FAIL;
                end
            end
            hts_pkg::PH_C_SLASH: begin
                priority if (hts_pkg::is_space(c)) begin
                    nxt = ph;
                end
                else if (hts_pkg::is_letter(c)) begin
                    nxt    = hts_pkg::PH_C_NAME;
                    nch    = hts_pkg::to_lower(c);
                    nvalid = 1'b1;
                    if (item.line_end) begin
                        st    = hts_pkg::ST_DONE;
                        nlast = 1'b1;
                    end
                end
                else begin
                    st = hts_pkg::ST_FAIL;
                end
            end
            hts_pkg::PH_C_NAME: begin
                if (hts_pkg::is_space(c) || c == hts_pkg::CH_GT || c == hts_pkg::CH_SLASH) begin
                    st    = hts_pkg::ST_DONE;
                    nlast = 1'b1;
                end
                else begin
                    nch    = hts_pkg::to_lower(c);
                    nvalid = 1'b1;
                    if (item.line_end) begin
                        st    = hts_pkg::ST_DONE;
                        nlast = 1'b1;
                    end
                end
            end
            default: begin
                st = hts_pkg::ST_IDLE;
            end
        endcase

        // an unfinished scan cannot run past the end of the line
        if (st == hts_pkg::ST_BUSY && item.line_end) begin
            st = hts_pkg::ST_FAIL;
        end
        if (st == hts_pkg::ST_FAIL) begin
            nch    = '0;
            nvalid = 1'b0;
            nlast  = 1'b0;
        end

        phase_next         = (st == hts_pkg::ST_BUSY) ? nxt : hts_pkg::PH_IDLE;
        is_close_next      = cls;
        result.scan_status = st;
        result.name_char   = nch;
        result.name_valid  = nvalid;
        result.name_last   = nlast;
    end

endmodule

// ===== design/html_tag_scanner.sv =====
// An accepted request is held in the input register; its result is registered.
// Throughput: one character per cycle unless the output stalls; the scan state
// register loops through the transition logic between input and result registers.
// Reset: rst_n (asynchronous, active low) empties both registers and puts the
// scanner in idle with open mode selected.
module html_tag_scanner (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  hts_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_stall,
    output hts_pkg::result_t result
);

    logic             hold_valid_reg;
    hts_pkg::item_t   hold_reg;
    logic             out_valid_reg;
    hts_pkg::result_t out_reg;
    hts_pkg::phase_t  phase_reg;
    logic             is_close_reg;

    hts_pkg::phase_t  phase_next;
    logic             is_close_next;
    hts_pkg::result_t step_result;

    logic out_free;
    logic advance;
    logic take;

    hts_step u_step (
        .item          (hold_reg),
        .phase         (phase_reg),
        .is_close      (is_close_reg),
        .phase_next    (phase_next),
        .is_close_next (is_close_next),
        .result        (step_result)
    );

    assign out_free   = !out_valid_reg || !result_stall;
    assign advance    = hold_valid_reg && out_free;
    assign item_stall = hold_valid_reg && !out_free;
    assign take       = item_valid && !item_stall;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            phase_reg      <= hts_pkg::PH_IDLE;
            is_close_reg   <= 1'b0;
        end
        else begin
            if (take) begin
                hold_valid_reg <= 1'b1;
            end
            else if (advance) begin
                hold_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                phase_reg     <= phase_next;
                is_close_reg  <= is_close_next;
            end
            else if (out_free) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers: load on request, hold otherwise
    always_ff @(posedge clk) begin
        if (take) begin
            hold_reg <= item;
        end
        if (advance) begin
            out_reg <= step_result;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

// ===== test/tb_html_tag_scanner.sv =====
module tb_html_tag_scanner;

    localparam int STALL_LIMIT = 2000;
    localparam int LONG_HOLD   = 300;
    localparam int DRAIN_WAIT  = 8;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             item_valid = 1'b0;
    logic             item_stall;
    hts_pkg::item_t   item = '0;
    logic             result_valid;
    logic             result_stall = 1'b0;
    hts_pkg::result_t result;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int holds_asked = 0;
    int holds_given = 0;
    int hold_left = 0;
    int quiet_cycles = 0;
    int fail_count = 0;
    int chars_sent = 0;
    int results_seen = 0;
    int tags_done = 0;
    int scans_failed = 0;

    // scanner state as the checker sees it
    hts_pkg::phase_t  tracked_phase = hts_pkg::PH_IDLE;
    logic             tracked_close = 1'b0;
    hts_pkg::result_t awaited_results[$];

    html_tag_scanner dut (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .item(item),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result(result)
    );

    always #1 clk = ~clk;

    function automatic logic char_blank(input logic [7:0] c);
        return c == hts_pkg::CH_SPACE || (c >= hts_pkg::CH_TAB && c <= hts_pkg::CH_CR);
    endfunction

    function automatic logic char_alpha(input logic [7:0] c);
        return (c >= hts_pkg::CH_UP_A && c <= hts_pkg::CH_UP_Z) ||
               (c >= hts_pkg::CH_LO_A && c <= hts_pkg::CH_LO_Z);
    endfunction

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        return (c >= hts_pkg::CH_UP_A && c <= hts_pkg::CH_UP_Z) ? (c | 8'h20) : c;
    endfunction

    // Advance the tracked scan by one character and return the token it yields.
    function automatic hts_pkg::result_t scan_char(input hts_pkg::item_t r);
        hts_pkg::phase_t  ph;
        hts_pkg::phase_t  nxt;
        hts_pkg::status_t st;
        logic [7:0]       c;
        hts_pkg::result_t res;
        c   = r.char_code;
        st  = hts_pkg::ST_BUSY;
        res = '0;
        if (r.start_scan)
        begin
            tracked_close = r.close_mode;
            ph = hts_pkg::PH_BEGIN;
        end
        else
        begin
            ph = tracked_phase;
        end
        nxt = ph;
        case (ph)
            hts_pkg::PH_BEGIN:
                if (c == hts_pkg::CH_LT)
                    nxt = tracked_close ? hts_pkg::PH_C_LT : hts_pkg::PH_LT;
                else
                    st = hts_pkg::ST_FAIL;
            hts_pkg::PH_LT:
                if (char_alpha(c))
                begin
                    nxt = hts_pkg::PH_TAG;
                    res.name_char  = fold_case(c);
                    res.name_valid = 1'b1;
                end
                else if (!char_blank(c))
                    st = hts_pkg::ST_FAIL;
            hts_pkg::PH_TAG:
                if (char_blank(c))
                begin
                    nxt = hts_pkg::PH_SPACE;
                    res.name_last = 1'b1;
                end
                else if (c == hts_pkg::CH_GT)
                begin
                    st = hts_pkg::ST_DONE;
                    res.name_last = 1'b1;
                end
                else
                begin
                    res.name_char  = fold_case(c);
                    res.name_valid = 1'b1;
                end
            hts_pkg::PH_SPACE:
                if (c == hts_pkg::CH_GT)
                    st = hts_pkg::ST_DONE;
                else if (c == hts_pkg::CH_QUOTE)
                    nxt = hts_pkg::PH_STR;
                else if (!char_blank(c))
                    nxt = hts_pkg::PH_ATTR;
            hts_pkg::PH_ATTR:
                if (c == hts_pkg::CH_QUOTE)
                    nxt = hts_pkg::PH_STR;
                else if (c == hts_pkg::CH_GT)
                    st = hts_pkg::ST_DONE;
            hts_pkg::PH_STR:
                if (c == hts_pkg::CH_QUOTE)
                    nxt = hts_pkg::PH_ATTR;
                else if (c == hts_pkg::CH_BSLASH)
                    nxt = hts_pkg::PH_ESC;
            hts_pkg::PH_ESC:
                nxt = hts_pkg::PH_STR;
            hts_pkg::PH_C_LT:
                if (c == hts_pkg::CH_SLASH)
                    nxt = hts_pkg::PH_C_SLASH;
                else if (!char_blank(c))
                    st = hts_pkg::ST_FAIL;
            hts_pkg::PH_C_SLASH:
                if (char_alpha(c))
                begin
                    nxt = hts_pkg::PH_C_NAME;
                    res.name_char  = fold_case(c);
                    res.name_valid = 1'b1;
                    if (r.line_end)
                    begin
                        st = hts_pkg::ST_DONE;
                        res.name_last = 1'b1;
                    end
                end
                else if (!char_blank(c))
                    st = hts_pkg::ST_FAIL;
            hts_pkg::PH_C_NAME:
                if (char_blank(c) || c == hts_pkg::CH_GT || c == hts_pkg::CH_SLASH)
                begin
                    st = hts_pkg::ST_DONE;
                    res.name_last = 1'b1;
                end
                else
                begin
                    res.name_char  = fold_case(c);
                    res.name_valid = 1'b1;
                    if (r.line_end)
                    begin
                        st = hts_pkg::ST_DONE;
                        res.name_last = 1'b1;
                    end
                end
            default:
                st = hts_pkg::ST_IDLE;
        endcase
        // a line that ends mid-scan fails it
        if (st == hts_pkg::ST_BUSY && r.line_end)
            st = hts_pkg::ST_FAIL;
        if (st == hts_pkg::ST_FAIL)
        begin
            res.name_char  = '0;
            res.name_valid = 1'b0;
            res.name_last  = 1'b0;
            scans_failed++;
        end
        if (st == hts_pkg::ST_DONE)
            tags_done++;
        tracked_phase   = (st == hts_pkg::ST_BUSY) ? nxt : hts_pkg::PH_IDLE;
        res.scan_status = st;
        return res;
    endfunction

    function automatic logic [7:0] pick_char(input logic [7:0] no_a, input logic [7:0] no_b,
                                             input logic no_blank);
        logic [7:0] c;
        do
            c = 8'($urandom_range(255));
        while (c == no_a || c == no_b || (no_blank && char_blank(c)));
        return c;
    endfunction

    function automatic logic [7:0] random_blank();
        return ($urandom_range(5) == 5) ? hts_pkg::CH_SPACE :
               8'(hts_pkg::CH_TAB + $urandom_range(4));
    endfunction

    function automatic logic [7:0] random_letter();
        return 8'((($urandom_range(1) == 1) ? hts_pkg::CH_UP_A : hts_pkg::CH_LO_A) +
                  $urandom_range(25));
    endfunction

    task automatic send_char(input logic [7:0] c, input logic start, input logic close,
                             input logic lend);
        hts_pkg::item_t r;
        r.char_code  = c;
        r.start_scan = start;
        r.close_mode = close;
        r.line_end   = lend;
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= r;
        do
            @(posedge clk);
        while (item_stall);
        awaited_results.push_back(scan_char(r));
        chars_sent++;
    endtask

    task automatic send_text(input string s, input logic start, input logic close,
                             input logic lend_last);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], start && i == 0, close, lend_last && i == s.len() - 1);
    endtask

    // Build one tag with random content, now and then broken, and send it.
    task automatic send_random_tag();
        logic [7:0] text[$];
        logic       close;
        logic       lend_last;
        int         restart_at;
        int         mode;
        int         cut;
        close     = 1'($urandom_range(1));
        lend_last = 1'b0;
        text.push_back(hts_pkg::CH_LT);
        repeat ($urandom_range(2)) text.push_back(random_blank());
        if (close)
        begin
            text.push_back(hts_pkg::CH_SLASH);
            repeat ($urandom_range(2)) text.push_back(random_blank());
        end
        text.push_back(random_letter());
        repeat ($urandom_range(4))
            text.push_back(pick_char(hts_pkg::CH_GT,
                                     close ? hts_pkg::CH_SLASH : hts_pkg::CH_GT, 1'b1));
        if (close)
        begin
            case ($urandom_range(3))
                0: text.push_back(random_blank());
                1: text.push_back(hts_pkg::CH_GT);
                2: text.push_back(hts_pkg::CH_SLASH);
                default: lend_last = 1'b1;
            endcase
            if (!lend_last)
                lend_last = $urandom_range(3) == 0;
        end
        else
        begin
            if ($urandom_range(3) != 0)
            begin
                text.push_back(random_blank());
                repeat ($urandom_range(3))
                begin
                    repeat ($urandom_range(4))
                        text.push_back(pick_char(hts_pkg::CH_GT, hts_pkg::CH_QUOTE, 1'b0));
                    text.push_back(hts_pkg::CH_QUOTE);
                    repeat ($urandom_range(5))
                        if ($urandom_range(4) == 0)
                        begin
                            text.push_back(hts_pkg::CH_BSLASH);
                            text.push_back(8'($urandom_range(255)));
                        end
                        else
                            text.push_back(pick_char(hts_pkg::CH_QUOTE, hts_pkg::CH_BSLASH,
                                                     1'b0));
                    text.push_back(hts_pkg::CH_QUOTE);
                    repeat ($urandom_range(2)) text.push_back(random_blank());
                end
            end
            text.push_back(hts_pkg::CH_GT);
            lend_last = $urandom_range(3) == 0;
        end
        restart_at = -1;
        mode = $urandom_range(99);
        if (mode < 6)
            text[$urandom_range(text.size() - 1)] = 8'($urandom_range(255));
        else if (mode < 10)
        begin
            // abandon the scan and start a new one mid-tag
            restart_at = $urandom_range(text.size() - 1, 1);
            text.insert(restart_at, hts_pkg::CH_LT);
        end
        cut = text.size() - 1;
        if (mode >= 90)
        begin
            // drop the line before the tag closes
            cut = $urandom_range(text.size() - 1);
            lend_last = 1'b1;
        end
        for (int i = 0; i <= cut; i++)
            send_char(text[i], i == 0 || i == restart_at,
                      (i == 0) ? close : 1'($urandom_range(1)), lend_last && i == cut);
    endtask

    task automatic wait_for_results();
        item_valid <= 1'b0;
        do
            @(posedge clk);
        while (awaited_results.size() != 0);
    endtask

    task automatic test_directed();
        send_char("x", 1'b0, 1'b0, 1'b0);
        // open tag: mixed case, slash inside the name, escaped quote in a value
        send_text("< Az/", 1'b1, 1'b0, 1'b0);
        send_char(hts_pkg::CH_CR, 1'b0, 1'b0, 1'b0);
        send_text("\"\\\"\">", 1'b0, 1'b0, 1'b0);
        // closing tag with a high byte in the name, ended by '>'
        send_text("<\t/Z", 1'b1, 1'b1, 1'b0);
        send_char(8'hFF, 1'b0, 1'b1, 1'b0);
        send_char(hts_pkg::CH_GT, 1'b0, 1'b0, 1'b0);
        // closing tag whose name runs to the line end
        send_text("</ a", 1'b1, 1'b1, 1'b1);
        send_text("<1", 1'b1, 1'b0, 1'b0);
        // restart mid-scan, then a line end inside the name
        send_char(hts_pkg::CH_LT, 1'b1, 1'b1, 1'b0);
        send_text("<q", 1'b1, 1'b0, 1'b1);
        send_char(8'h00, 1'b1, 1'b0, 1'b0);
    endtask

    task automatic test_random_stream(input int target);
        int goal;
        goal = chars_sent + target;
        while (chars_sent < goal)
            if ($urandom_range(99) < 80)
                send_random_tag();
            else
                send_char(8'($urandom_range(255)), $urandom_range(7) == 0,
                          1'($urandom_range(1)), $urandom_range(7) == 0);
    endtask

    task automatic test_stall_fill();
        int goal;
        holds_asked++;
        goal = chars_sent + 40;
        while (chars_sent < goal)
            send_random_tag();
    endtask

    task automatic test_drain_pause();
        repeat (6)
        begin
            send_random_tag();
            wait_for_results();
        end
    endtask

    // result-side stall: random, or one long hold when asked
    always @(posedge clk)
    begin
        if (holds_asked != holds_given)
        begin
            holds_given = holds_asked;
            hold_left   = LONG_HOLD;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            result_stall <= 1'b1;
        end
        else
            result_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin
        hts_pkg::result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            results_seen++;
            if (awaited_results.size() == 0)
            begin
                $error("result with no request pending, scan_status %0d", result.scan_status);
                fail_count++;
            end
            else
            begin
                want = awaited_results.pop_front();
                if (result.scan_status !== want.scan_status)
                begin
                    $error("scan_status expected %0d got %0d", want.scan_status,
                           result.scan_status);
                    fail_count++;
                end
                if (result.name_char !== want.name_char)
                begin
                    $error("name_char expected %02h got %02h", want.name_char,
                           result.name_char);
                    fail_count++;
                end
                if (result.name_valid !== want.name_valid)
                begin
                    $error("name_valid expected %0d got %0d", want.name_valid,
                           result.name_valid);
                    fail_count++;
                end
                if (result.name_last !== want.name_last)
                begin
                    $error("name_last expected %0d got %0d", want.name_last,
                           result.name_last);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Timeout: no handshake for %0d cycles", STALL_LIMIT);
            $display("html_tag_scanner test failed");
            $finish;
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_idle_pct = 12;
        recv_idle_pct = 53;
        test_directed();
        test_random_stream(130);
        test_stall_fill();
        send_idle_pct = 53;
        recv_idle_pct = 12;
        test_random_stream(130);
        test_drain_pause();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_stream(130);
        wait_for_results();
        repeat (DRAIN_WAIT) @(posedge clk);
        $display("Checked %0d results from %0d characters: %0d tags completed, %0d scans failed",
                 results_seen, chars_sent, tags_done, scans_failed);
        $display("Open and closing tags, quoted values with escapes, restarts, early line ends");
        $display("and a long output hold that backed up the input were all exercised.");
        if (fail_count == 0)
            $display("html_tag_scanner test passed");
        else
            $display("html_tag_scanner test failed");
        $finish;
    end

endmodule

// ===== files.f =====
design/hts_pkg.sv
design/hts_step.sv
design/html_tag_scanner.sv
test/tb_html_tag_scanner.sv
